### design/qmn_pkg.sv
// package: widths, payload types and pipeline constants of the quaternion block
`default_nettype none
package qmn_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 14;

    // product pre-shift keeps very wide sums in range
    localparam int PROD_SHIFT = (DATA_WIDTH > 31) ? (2 * DATA_WIDTH - 62) : 0;
    // product operand width (holds the negated most negative component)
    localparam int OW  = DATA_WIDTH + 1;
    localparam int PRW = 2 * OW - PROD_SHIFT;
    localparam int HW  = PRW + 2;
    localparam int PW  = $clog2(HW);
    // normalized magnitude width, top bit at position MW-1
    localparam int MW  = 30;
    localparam int SW  = 2 * MW + 2;
    localparam int RW  = MW + 1;
    localparam int SQ_STEPS = MW + 1;
    localparam int QB  = FRAC_BITS + 1;
    localparam int NW  = MW + FRAC_BITS + 1;
    localparam int CW  = ((QB > DATA_WIDTH) ? QB : DATA_WIDTH) + 1;

    typedef logic signed [DATA_WIDTH-1:0] comp_t;
    typedef comp_t [3:0]                   quat_t;
    typedef logic signed [OW-1:0]         op_t;
    typedef op_t [3:0]                     oquat_t;
    typedef logic signed [PRW-1:0]        prod_t;
    typedef logic signed [HW-1:0]         wide_t;
    typedef wide_t [3:0]                   wquat_t;

    typedef struct packed {
        logic  mode;
        logic  deg;
        quat_t a;
        quat_t b;
    } side_t;

    typedef struct packed {
        logic [3:0][MW-1:0] m;
        logic [3:0]         neg;
        logic               zero;
        side_t              side;
    } ctl_t;

    typedef struct packed {
        logic  mode;
        comp_t a_x;
        comp_t a_y;
        comp_t a_z;
        comp_t a_w;
        comp_t b_x;
        comp_t b_y;
        comp_t b_z;
        comp_t b_w;
    } in_beat_t;

    typedef struct packed {
        comp_t out_x;
        comp_t out_y;
        comp_t out_z;
        comp_t out_w;
        logic  degenerate;
    } out_beat_t;

endpackage
`default_nettype wire

### design/qmn_stream_if.sv
// interfaces: valid/ready channels for input and result beats
`default_nettype none
interface qmn_in_if import qmn_pkg::*;;
    logic     valid;
    logic     ready;
    in_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface qmn_out_if import qmn_pkg::*;;
    logic      valid;
    logic      ready;
    out_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/qmn_hprod.sv
// two-stage pipelined hamilton product
`default_nettype none
module qmn_hprod import qmn_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   en,
    input  wire logic   in_valid,
    input  wire oquat_t a,
    input  wire oquat_t b,
    input  wire side_t  in_side,
    output logic        out_valid,
    output wquat_t      r,
    output side_t       out_side
);

    logic signed [2*OW-1:0] full [4][4];
    prod_t                  pr_next [4][4];
    prod_t                  pr_reg [4][4];
    side_t                  side1_reg;
    wquat_t                 r_next;
    wquat_t                 r_reg;
    side_t                  side2_reg;
    logic [1:0]             vld_reg;

    // all sixteen cross products
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                full[i][j]    = $signed(a[i]) * $signed(b[j]);
                pr_next[i][j] = PRW'(full[i][j] >>> PROD_SHIFT);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_reg    <= pr_next;
            side1_reg <= in_side;
        end
    end

    // component sums, order x y z w
    always_comb
    begin
        r_next[0] = HW'(pr_reg[3][0]) + HW'(pr_reg[0][3]) + HW'(pr_reg[1][2])
                  - HW'(pr_reg[2][1]);
        r_next[1] = HW'(pr_reg[3][1]) + HW'(pr_reg[1][3]) + HW'(pr_reg[2][0])
                  - HW'(pr_reg[0][2]);
        r_next[2] = HW'(pr_reg[3][2]) + HW'(pr_reg[2][3]) + HW'(pr_reg[0][1])
                  - HW'(pr_reg[1][0]);
        r_next[3] = HW'(pr_reg[3][3]) - HW'(pr_reg[0][0]) - HW'(pr_reg[1][1])
                  - HW'(pr_reg[2][2]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg     <= r_next;
            side2_reg <= side1_reg;
        end
    end

    // valid travels with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[0], in_valid};
    end

    assign out_valid = vld_reg[1];
    assign r         = r_reg;
    assign out_side  = side2_reg;

endmodule
`default_nettype wire

### design/qmn_unitize.sv
// pipelined unit-length scaling: normalize, square-sum, bit-serial sqrt, divide
`default_nettype none
module qmn_unitize import qmn_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   en,
    input  wire logic   in_valid,
    input  wire wquat_t v,
    input  wire side_t  in_side,
    output logic        out_valid,
    output quat_t       o,
    output logic        zero,
    output side_t       out_side
);

    localparam int LAT = 5 + SQ_STEPS + 1 + QB + 1;
    localparam logic [CW-1:0] NEG_LIM = CW'(1) << (DATA_WIDTH - 1);
    localparam logic [CW-1:0] POS_LIM = NEG_LIM - CW'(1);

    logic [3:0][HW-1:0]    mag_next;
    logic [3:0][HW-1:0]    m1_reg;
    logic [3:0]            neg1_reg;
    side_t                 side1_reg;
    logic [HW-1:0]         or_all;
    logic [PW-1:0]         p_next;
    logic [3:0][HW-1:0]    m2_reg;
    logic [3:0]            neg2_reg;
    logic [PW-1:0]         p2_reg;
    logic                  zero2_reg;
    side_t                 side2_reg;
    logic [HW+MW-1:0]      ext [4];
    ctl_t                  c3_next;
    ctl_t                  c3_reg;
    logic [3:0][2*MW-1:0]  sq4_reg;
    ctl_t                  c4_reg;
    logic [SW-1:0]         sq_s_reg [SQ_STEPS+1];
    logic [SW-1:0]         sq_r_reg [SQ_STEPS+1];
    ctl_t                  sq_c_reg [SQ_STEPS+1];
    logic [RW-1:0]         root;
    logic [3:0][NW:0]      dv_rem_reg [QB+1];
    logic [3:0][QB-1:0]    dv_q_reg [QB+1];
    logic [RW-1:0]         dv_l_reg [QB+1];
    ctl_t                  dv_c_reg [QB+1];
    quat_t                 o_next;
    quat_t                 o_reg;
    logic                  zero_reg;
    side_t                 side_reg;
    logic [LAT-1:0]        vld_reg;

    // magnitudes and signs
    always_comb
    begin
        for (int i = 0; i < 4; i++)
            mag_next[i] = v[i][HW-1] ? HW'(-v[i]) : HW'(v[i]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_reg    <= mag_next;
            for (int i = 0; i < 4; i++)
                neg1_reg[i] <= v[i][HW-1];
            side1_reg <= in_side;
        end
    end

    // leading one of the largest magnitude
    always_comb
    begin
        or_all = m1_reg[0] | m1_reg[1] | m1_reg[2] | m1_reg[3];
        p_next = '0;
        for (int i = 0; i < HW; i++)
        begin
            if (or_all[i])
                p_next = PW'(i);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m2_reg    <= m1_reg;
            neg2_reg  <= neg1_reg;
            p2_reg    <= p_next;
            zero2_reg <= (or_all == '0);
            side2_reg <= side1_reg;
        end
    end

    // common shift that puts the largest top bit at MW-1
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (p2_reg > PW'(MW - 1))
                ext[i] = (HW+MW)'(m2_reg[i]) >> (p2_reg - PW'(MW - 1));
            else
                ext[i] = (HW+MW)'(m2_reg[i]) << (PW'(MW - 1) - p2_reg);
            c3_next.m[i] = ext[i][MW-1:0];
        end
        c3_next.neg  = neg2_reg;
        c3_next.zero = zero2_reg;
        c3_next.side = side2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            c3_reg <= c3_next;
    end

    // squares
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
                sq4_reg[i] <= (2*MW)'(c3_reg.m[i]) * (2*MW)'(c3_reg.m[i]);
            c4_reg <= c3_reg;
        end
    end

    // sum of squares
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_s_reg[0] <= SW'(sq4_reg[0]) + SW'(sq4_reg[1]) + SW'(sq4_reg[2])
                         + SW'(sq4_reg[3]);
            sq_r_reg[0] <= '0;
            sq_c_reg[0] <= c4_reg;
        end
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        localparam logic [SW-1:0] BIT = SW'(1) << (2 * (SQ_STEPS - 1 - k));
        logic [SW-1:0] trial;
        logic [SW-1:0] s_next;
        logic [SW-1:0] r_next;

        always_comb
        begin
            trial = sq_r_reg[k] + BIT;
            if (sq_s_reg[k] >= trial)
            begin
                s_next = sq_s_reg[k] - trial;
                r_next = (sq_r_reg[k] >> 1) + BIT;
            end
            else
            begin
                s_next = sq_s_reg[k];
                r_next = sq_r_reg[k] >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_s_reg[k+1] <= s_next;
                sq_r_reg[k+1] <= r_next;
                sq_c_reg[k+1] <= sq_c_reg[k];
            end
        end
    end

    assign root = sq_r_reg[SQ_STEPS][RW-1:0];

    // rounded dividend
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
                dv_rem_reg[0][i] <= ((NW+1)'(sq_c_reg[SQ_STEPS].m[i]) << FRAC_BITS)
                                  + (NW+1)'(root >> 1);
            dv_q_reg[0] <= '0;
            dv_l_reg[0] <= root;
            dv_c_reg[0] <= sq_c_reg[SQ_STEPS];
        end
    end

    // restoring division, one quotient bit per stage in four lanes
    for (genvar j = 0; j < QB; j++)
    begin : g_div
        localparam int QI = QB - 1 - j;
        logic [NW:0]         dsh;
        logic [3:0][NW:0]    rem_next;
        logic [3:0][QB-1:0]  q_next;

        always_comb
        begin
            dsh = (NW+1)'(dv_l_reg[j]) << QI;
            for (int i = 0; i < 4; i++)
            begin
                rem_next[i] = dv_rem_reg[j][i];
                q_next[i]   = dv_q_reg[j][i];
                if (dv_rem_reg[j][i] >= dsh)
                begin
                    rem_next[i]  = dv_rem_reg[j][i] - dsh;
                    q_next[i][QI] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_rem_reg[j+1] <= rem_next;
                dv_q_reg[j+1]   <= q_next;
                dv_l_reg[j+1]   <= dv_l_reg[j];
                dv_c_reg[j+1]   <= dv_c_reg[j];
            end
        end
    end

    // sign restore and saturation
    always_comb
    begin
        logic [CW-1:0] qe;
        logic [CW-1:0] lim;
        for (int i = 0; i < 4; i++)
        begin
            qe = CW'(dv_q_reg[QB][i]);
            if (dv_c_reg[QB].neg[i])
            begin
                lim       = (qe > NEG_LIM) ? NEG_LIM : qe;
                o_next[i] = DATA_WIDTH'(-lim);
            end
            else
            begin
                lim       = (qe > POS_LIM) ? POS_LIM : qe;
                o_next[i] = DATA_WIDTH'(lim);
            end
            if (dv_c_reg[QB].zero)
                o_next[i] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_reg    <= o_next;
            zero_reg <= dv_c_reg[QB].zero;
            side_reg <= dv_c_reg[QB].side;
        end
    end

    // valid travels with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
    end

    assign out_valid = vld_reg[LAT-1];
    assign o         = o_reg;
    assign zero      = zero_reg;
    assign out_side  = side_reg;

endmodule
`default_nettype wire

### design/quaternion_multiply_normalize_top.sv
// Quaternion multiply / vector rotate with unit-length normalization, pipelined.
// Input channel req carries mode and the quaternions a and b; result channel rsp
// carries out_x..out_w and degenerate. A beat moves when valid and ready are high.
// Mode 0 returns the normalized product a*b; mode 1 rotates the vector in b by a
// and returns x, y, z with w zero. Every beat goes through the same path: vector
// normalization, product, normalization, product with conj(a), normalization.
// Each normalization unit is 53 stages at the default widths (31-stage bit-serial
// square root, 15-stage restoring divider); each product unit is 2 stages.
// Throughput: one beat per cycle while not stalled; the whole pipeline advances as one.
// A held result in the output register stalls the pipeline, and req.ready drops
// until rsp.ready takes it; nothing is lost or repeated during a stall.
// Reset clears all valid bits; data registers are not reset.
`default_nettype none
module quaternion_multiply_normalize_top import qmn_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    qmn_in_if.sink    req,
    qmn_out_if.source rsp
);

    logic      en;
    wquat_t    u0_v;
    side_t     u0_in_side;
    logic      u0_valid;
    quat_t     u0_o;
    logic      u0_zero;
    side_t     u0_side;
    oquat_t    h1_a;
    oquat_t    h1_b;
    side_t     h1_in_side;
    logic      h1_valid;
    wquat_t    h1_r;
    side_t     h1_side;
    logic      u1_valid;
    quat_t     u1_o;
    logic      u1_zero;
    side_t     u1_side;
    oquat_t    h2_a;
    oquat_t    h2_b;
    side_t     h2_in_side;
    logic      h2_valid;
    wquat_t    h2_r;
    side_t     h2_side;
    logic      u2_valid;
    quat_t     u2_o;
    logic      u2_zero;
    side_t     u2_side;
    out_beat_t out_next;
    out_beat_t out_reg;
    logic      out_valid_reg;
    logic      fdeg;

    // global advance: output register empty or being taken
    assign en        = !out_valid_reg || rsp.ready;
    assign req.ready = en;

    // vector part of b as a pure quaternion
    always_comb
    begin
        u0_v[0] = HW'($signed(req.data.b_x));
        u0_v[1] = HW'($signed(req.data.b_y));
        u0_v[2] = HW'($signed(req.data.b_z));
        u0_v[3] = '0;
        u0_in_side.mode = req.data.mode;
        u0_in_side.deg  = 1'b0;
        u0_in_side.a    = {req.data.a_w, req.data.a_z, req.data.a_y, req.data.a_x};
        u0_in_side.b    = {req.data.b_w, req.data.b_z, req.data.b_y, req.data.b_x};
    end

    qmn_unitize u_unit0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (req.valid),
        .v         (u0_v),
        .in_side   (u0_in_side),
        .out_valid (u0_valid),
        .o         (u0_o),
        .zero      (u0_zero),
        .out_side  (u0_side)
    );

    // first product: a times b, or a times the unit vector
    always_comb
    begin
        h1_in_side     = u0_side;
        h1_in_side.deg = u0_side.mode & u0_zero;
        for (int i = 0; i < 4; i++)
        begin
            h1_a[i] = OW'($signed(u0_side.a[i]));
            h1_b[i] = u0_side.mode ? OW'($signed(u0_o[i])) : OW'($signed(u0_side.b[i]));
        end
    end

    qmn_hprod u_prod1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (u0_valid),
        .a         (h1_a),
        .b         (h1_b),
        .in_side   (h1_in_side),
        .out_valid (h1_valid),
        .r         (h1_r),
        .out_side  (h1_side)
    );

    qmn_unitize u_unit1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (h1_valid),
        .v         (h1_r),
        .in_side   (h1_side),
        .out_valid (u1_valid),
        .o         (u1_o),
        .zero      (u1_zero),
        .out_side  (u1_side)
    );

    // second product with conj(a); the first unit result rides in side.b
    always_comb
    begin
        h2_in_side     = u1_side;
        h2_in_side.deg = u1_side.deg | u1_zero;
        h2_in_side.b   = u1_o;
        for (int i = 0; i < 4; i++)
            h2_a[i] = OW'($signed(u1_o[i]));
        for (int i = 0; i < 3; i++)
            h2_b[i] = -OW'($signed(u1_side.a[i]));
        h2_b[3] = OW'($signed(u1_side.a[3]));
    end

    qmn_hprod u_prod2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (u1_valid),
        .a         (h2_a),
        .b         (h2_b),
        .in_side   (h2_in_side),
        .out_valid (h2_valid),
        .r         (h2_r),
        .out_side  (h2_side)
    );

    qmn_unitize u_unit2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (h2_valid),
        .v         (h2_r),
        .in_side   (h2_side),
        .out_valid (u2_valid),
        .o         (u2_o),
        .zero      (u2_zero),
        .out_side  (u2_side)
    );

    // result select by mode, zero on a degenerate beat
    always_comb
    begin
        if (u2_side.mode)
        begin
            fdeg           = u2_side.deg | u2_zero;
            out_next.out_x = u2_o[0];
            out_next.out_y = u2_o[1];
            out_next.out_z = u2_o[2];
        end
        else
        begin
            fdeg           = u2_side.deg;
            out_next.out_x = u2_side.b[0];
            out_next.out_y = u2_side.b[1];
            out_next.out_z = u2_side.b[2];
        end
        out_next.out_w      = u2_side.mode ? '0 : u2_side.b[3];
        out_next.degenerate = fdeg;
        if (fdeg)
        begin
            out_next.out_x = '0;
            out_next.out_y = '0;
            out_next.out_z = '0;
            out_next.out_w = '0;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= u2_valid;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    // degenerate beats carry all-zero components
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.data.degenerate |->
            rsp.data.out_x == '0 && rsp.data.out_y == '0 &&
            rsp.data.out_z == '0 && rsp.data.out_w == '0)
        else $error("degenerate result with nonzero component");

    // a unit result always has some nonzero component
    a_unit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.data.degenerate |->
            rsp.data.out_x != '0 || rsp.data.out_y != '0 ||
            rsp.data.out_z != '0 || rsp.data.out_w != '0)
        else $error("normal result is all zero");

    // a stalled result stays in place until taken
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
        else $error("stalled result lost or changed");

endmodule
`default_nettype wire
